// ===== rtl/sst_pkg.sv =====
// sst_pkg: item types, command and status codes and cell control for sorted_set_table.
// No dependencies; imported by sst_cell and sorted_set_table.
package sst_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    // Command codes
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_FIND   = 3'd1;
    localparam logic [2:0] CMD_ERASE  = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    typedef struct packed {
        logic [2:0]                command;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } req_item_t;

    typedef struct packed {
        logic                      found;
        logic [INDEX_W-1:0]        position;
        logic signed [VALUE_W-1:0] element;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
        logic [2:0]                status;
    } rsp_item_t;

    typedef enum logic [1:0] {
        SHIFT_HOLD,
        SHIFT_UP,
        SHIFT_DOWN
    } shift_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        shift_t                    op;
        logic signed [VALUE_W-1:0] value;
    } cell_ctl_t;

endpackage

// ===== rtl/sorted_set_table.sv =====
// sorted_set_table: bounded ascending set of signed 32-bit values built as a chain
// of sst_cell slots. Depends on sst_pkg and sst_cell.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one command item: insert, find,
//   erase, clear or read_at. rsp channel (rsp_valid/rsp_ready/rsp) returns exactly
//   one result item per command, with found, position, element, count, is_empty
//   and status.
//   The result is registered and appears in the cycle after the command is taken.
//   Throughput: one command per cycle while rsp_ready is high; each slot compares
//   against the value at once and the chain shifts by one place in the same cycle.
//   The set holds up to CAPACITY values; position and count are reported masked
//   to their 4 and 5 bit fields.
//   Reset: the count goes to zero, so the set is empty; slot contents are only
//   ever read below the count and need no clearing.
//   Stall: while a result waits on rsp_ready low, req_ready is low too; a new
//   command is taken in the cycle the waiting result leaves.
//   Duplicate inserts and inserts into a full set leave the set untouched and
//   are flagged in status.
module sorted_set_table #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  sst_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output sst_pkg::rsp_item_t rsp
);
    import sst_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RD = (CAPACITY < (1 << INDEX_W)) ? CAPACITY : (1 << INDEX_W);

    logic [CW-1:0]    count_reg, count_next;
    logic             rsp_valid_reg;
    rsp_item_t        rsp_reg, rsp_next;

    cell_ctl_t        ctl;
    logic             accept;
    logic             hit, full, idx_ok;
    logic [INDEX_W-1:0] pos;
    logic signed [VALUE_W-1:0] read_elem;
    logic [CW+COUNT_W-1:0] count_wide;

    logic signed [VALUE_W-1:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0]       less_w;
    logic [CAPACITY-1:0]       eq_w;
    logic [CAPACITY-1:0]       first_w;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---- cell chain ----
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam logic [CW-1:0] CELL_IDX = CW'(gi);
            logic                      occ;
            logic                      l_less;
            logic signed [VALUE_W-1:0] l_entry;
            logic signed [VALUE_W-1:0] r_entry;

            assign occ = CELL_IDX < count_reg;

            if (gi == 0)
            begin : g_first
                assign l_less  = 1'b1;
                assign l_entry = '0;
            end
            else
            begin : g_mid
                assign l_less  = less_w[gi-1];
                assign l_entry = entry_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign r_entry = '0;
            end
            else
            begin : g_inner
                assign r_entry = entry_w[gi+1];
            end

            sst_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (occ),
                .left_less   (l_less),
                .left_entry  (l_entry),
                .right_entry (r_entry),
                .entry       (entry_w[gi]),
                .less        (less_w[gi]),
                .eq          (eq_w[gi]),
                .first_ge    (first_w[gi])
            );
        end
    endgenerate

    // ---- match, position and read_at selection ----
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_w[i])
            begin
                pos = pos | INDEX_W'(i);
            end
        end
    end

    always_comb
    begin
        read_elem = '0;
        for (int j = 0; j < RD; j++)
        begin
            if (req.index == INDEX_W'(j))
            begin
                read_elem = read_elem | entry_w[j];
            end
        end
    end

    assign hit    = |eq_w;
    assign full   = (count_reg == CW'(CAPACITY));
    assign idx_ok = ({{CW{1'b0}}, req.index} < {{INDEX_W{1'b0}}, count_reg});

    // shift command broadcast to the chain
    always_comb
    begin
        ctl.value = req.value;
        ctl.op    = SHIFT_HOLD;
        if (accept && req.command == CMD_INSERT && !hit && !full)
        begin
            ctl.op = SHIFT_UP;
        end
        else if (accept && req.command == CMD_ERASE && hit)
        begin
            ctl.op = SHIFT_DOWN;
        end
    end

    // ---- count and result ----
    always_comb
    begin
        count_next        = count_reg;
        rsp_next.found    = 1'b0;
        rsp_next.position = '0;
        rsp_next.element  = '0;
        rsp_next.status   = ST_OK;

        case (req.command)
            CMD_INSERT:
            begin
                if (hit)
                begin
                    rsp_next.found    = 1'b1;
                    rsp_next.position = pos;
                    rsp_next.status   = ST_DUP;
                end
                else if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    rsp_next.position = pos;
                    count_next        = count_reg + CW'(1);
                end
            end
            CMD_FIND:
            begin
                if (hit)
                begin
                    rsp_next.found    = 1'b1;
                    rsp_next.position = pos;
                end
                else
                begin
                    rsp_next.status = ST_MISSING;
                end
            end
            CMD_ERASE:
            begin
                if (hit)
                begin
                    rsp_next.found    = 1'b1;
                    rsp_next.position = pos;
                    count_next        = count_reg - CW'(1);
                end
                else
                begin
                    rsp_next.status = ST_MISSING;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            CMD_READ:
            begin
                if (idx_ok)
                begin
                    rsp_next.found    = 1'b1;
                    rsp_next.position = req.index;
                    rsp_next.element  = read_elem;
                end
                else
                begin
                    rsp_next.status = ST_RANGE;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        count_wide        = {{COUNT_W{1'b0}}, count_next};
        rsp_next.count    = count_wide[COUNT_W-1:0];
        rsp_next.is_empty = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef NO_ASSERTIONS
    // count never runs past the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("count exceeds capacity");

    // at most one boundary slot in the chain
    a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_w))
        else $error("more than one boundary slot");

    // a waiting result agrees with the held count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.is_empty == (count_reg == '0)))
        else $error("is_empty disagrees with count");

    // a duplicate insert must not change the count
    a_dup_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.command == CMD_INSERT && hit) |=> $stable(count_reg))
        else $error("duplicate insert changed count");
`endif

endmodule

// ===== rtl/sst_cell.sv =====
// sst_cell: one slot of the sorted chain; compares against the broadcast value
// and shifts with its neighbours. Depends on sst_pkg.
module sst_cell (
    input  logic                               clk,
    input  sst_pkg::cell_ctl_t                 ctl,
    input  logic                               occupied,
    input  logic                               left_less,
    input  logic signed [sst_pkg::VALUE_W-1:0] left_entry,
    input  logic signed [sst_pkg::VALUE_W-1:0] right_entry,
    output logic signed [sst_pkg::VALUE_W-1:0] entry,
    output logic                               less,
    output logic                               eq,
    output logic                               first_ge
);
    import sst_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;

    assign less     = occupied && (entry_reg < ctl.value);
    assign eq       = occupied && (entry_reg == ctl.value);
    // boundary of the thermometer: first slot not below the value
    assign first_ge = !less && left_less;
    assign entry    = entry_reg;

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            SHIFT_UP:
            begin
                if (!less)
                begin
                    entry_reg <= left_less ? ctl.value : left_entry;
                end
            end
            SHIFT_DOWN:
            begin
                if (!less)
                begin
                    entry_reg <= right_entry;
                end
            end
            default:
            begin
                entry_reg <= entry_reg;
            end
        endcase
    end

endmodule
